// ===== hdl/assert_macros.svh =====
// Assertion shorthands for the peak finder RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define GLP_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define GLP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/glp_pkg.sv =====
// Shared types and constants of the grid local peak finder.
// No dependencies; imported by the cell and the top level.
package glp_pkg;

    // result field widths
    localparam int ROW_PORT_W = 7;
    localparam int COL_PORT_W = 5;

    // configuration port
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int ROWS_CFG_W = 8;
    localparam int COLS_CFG_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 8'd1;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 6'd1;

    // control broadcast to every cell of the line chain
    typedef struct packed {
        logic shift;   // rotate the chain by one column
        logic clear;   // zero the upper line (new frame)
    } cell_ctl_t;

endpackage

// ===== hdl/glp_if.sv =====
// Stream interfaces of the peak finder: sample words in, peak words out.
// Depends on glp_pkg for the result field widths.
interface glp_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface glp_peak_if;
    logic                            valid;
    logic                            ready;
    logic [glp_pkg::ROW_PORT_W-1:0]  peak_row;
    logic [glp_pkg::COL_PORT_W-1:0]  peak_col;
    logic                            last_of_run;

    modport source (output valid, output peak_row, output peak_col, output last_of_run,
                    input ready);
    modport sink   (input valid, input peak_row, input peak_col, input last_of_run,
                    output ready);
endinterface

// ===== hdl/glp_cell.sv =====
// One column cell of the line chain: holds the upper and middle line values.
// Depends on glp_pkg (cell_ctl_t).
module glp_cell import glp_pkg::*; #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cell_ctl_t    ctl,
    input  logic         is_tail,
    input  logic [W-1:0] nbr_upper,
    input  logic [W-1:0] nbr_middle,
    input  logic [W-1:0] ins_upper,
    input  logic [W-1:0] ins_middle,
    output logic [W-1:0] upper,
    output logic [W-1:0] middle
);

    logic [W-1:0] upper_reg;
    logic [W-1:0] upper_next;
    logic [W-1:0] middle_reg;
    logic [W-1:0] middle_next;

    // tail cell takes the new column, others take their right neighbor
    always_comb
    begin
        upper_next  = is_tail ? ins_upper  : nbr_upper;
        middle_next = is_tail ? ins_middle : nbr_middle;
    end

    // upper line: zero at reset and at frame start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= '0;
        end
        else if (ctl.clear)
        begin
            upper_reg <= '0;
        end
        else if (ctl.shift)
        begin
            upper_reg <= upper_next;
        end
    end

    // middle line: written in the first row before any read
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            middle_reg <= middle_next;
        end
    end

    assign upper  = upper_reg;
    assign middle = middle_reg;

endmodule

// ===== hdl/grid_local_peak_finder_top.sv =====
// Top level of the grid local peak finder: position control, judge, output stage.
// Depends on glp_pkg, glp_if (stream interfaces), glp_cell and assert_macros.svh.
//
//  channel   dir  words                              handshake
//  samples   in   sample                             valid/ready
//  peaks     out  peak_row, peak_col, last_of_run    valid/ready
//  cfg       in   cfg_we, cfg_index, cfg_wdata       write enable, no wait
//
// One sample per cycle while the output stage can take a result; the rotating
// chain of column cells supplies center, up and right for the judge each cycle.
// After the last sample of a frame no sample is taken: the chain rotates
// once through the last row to judge it against a zero row, then the last
// pending result is sent. A stalled output holds the sample input and the flush.
// Reset (rst_n, async) clears positions, the upper line and the registers to 1.
`include "assert_macros.svh"

module grid_local_peak_finder_top import glp_pkg::*; #(
    parameter int MAX_COLS     = 32,
    parameter int MAX_ROWS     = 128,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    glp_sample_if.sink            samples,
    glp_peak_if.source            peaks,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ROW_W = (MAX_ROWS > 128) ? $clog2(MAX_ROWS) : ROW_PORT_W;
    localparam int COL_W = (MAX_COLS > 32)  ? $clog2(MAX_COLS) : COL_PORT_W;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_FIN
    } state_t;

    typedef logic [SAMPLE_WIDTH-1:0] sample_t;

    state_t                 state_reg,     state_next;
    logic [ROW_W-1:0]       row_pos_reg,   row_pos_next;
    logic [COL_W-1:0]       col_pos_reg,   col_pos_next;
    logic                   hold_valid_reg, hold_valid_next;
    logic [ROW_W-1:0]       hold_row_reg,  hold_row_next;
    logic [COL_W-1:0]       hold_col_reg,  hold_col_next;
    sample_t                left_reg,      left_next;
    logic [ROWS_CFG_W-1:0]  rows_cfg_reg,  rows_cfg_next;
    logic [COLS_CFG_W-1:0]  cols_cfg_reg,  cols_cfg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ROW_PORT_W-1:0]  out_row_reg,   out_row_next;
    logic [COL_PORT_W-1:0]  out_col_reg,   out_col_next;
    logic                   out_last_reg,  out_last_next;

    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] last_col;

    cell_ctl_t cell_ctl;
    sample_t   ins_upper;
    sample_t   ins_middle;
    sample_t   cell_upper  [MAX_COLS];
    sample_t   cell_middle [MAX_COLS];
    sample_t   right_src;

    sample_t centre, up_val, down_val, left_val, right_val;
    logic    ge_all;
    logic    advance;
    logic    sample_accept;
    logic    push;
    logic    push_last;
    logic [ROW_W-1:0] push_row;
    logic [COL_W-1:0] push_col;
    logic    peak_now;

    // clamp the frame size registers to the supported range
    always_comb
    begin
        if (rows_cfg_reg == '0)
        begin
            last_row = '0;
        end
        else if (32'(rows_cfg_reg) > MAX_ROWS)
        begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end
        else
        begin
            last_row = ROW_W'(32'(rows_cfg_reg) - 32'd1);
        end

        if (cols_cfg_reg == '0)
        begin
            last_col = '0;
        end
        else if (32'(cols_cfg_reg) > MAX_COLS)
        begin
            last_col = COL_W'(MAX_COLS - 1);
        end
        else
        begin
            last_col = COL_W'(32'(cols_cfg_reg) - 32'd1);
        end
    end

    // line chain: cell 0 is the column being judged, the active length rotates
    for (genvar i = 0; i < MAX_COLS; i++)
    begin : g_cell
        sample_t nbr_upper;
        sample_t nbr_middle;

        if (i + 1 < MAX_COLS)
        begin : g_link
            assign nbr_upper  = cell_upper[i+1];
            assign nbr_middle = cell_middle[i+1];
        end
        else
        begin : g_end
            assign nbr_upper  = '0;
            assign nbr_middle = '0;
        end

        glp_cell #(
            .W (SAMPLE_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl),
            .is_tail    (COL_W'(i) == last_col),
            .nbr_upper  (nbr_upper),
            .nbr_middle (nbr_middle),
            .ins_upper  (ins_upper),
            .ins_middle (ins_middle),
            .upper      (cell_upper[i]),
            .middle     (cell_middle[i])
        );
    end

    if (MAX_COLS > 1)
    begin : g_right
        assign right_src = cell_middle[1];
    end
    else
    begin : g_no_right
        assign right_src = '0;
    end

    // four-neighbor judge; outside the grid reads as zero
    always_comb
    begin
        centre    = cell_middle[0];
        up_val    = cell_upper[0];
        down_val  = (state_reg == ST_FLUSH) ? '0 : samples.sample;
        left_val  = (col_pos_reg == '0) ? '0 : left_reg;
        right_val = (col_pos_reg == last_col) ? '0 : right_src;
        ge_all    = ($signed(centre) >= $signed(up_val))
                 && ($signed(centre) >= $signed(down_val))
                 && ($signed(centre) >= $signed(left_val))
                 && ($signed(centre) >= $signed(right_val));
    end

    assign advance       = !out_valid_reg || peaks.ready;
    assign samples.ready = (state_reg == ST_RUN) && advance;
    assign sample_accept = samples.valid && samples.ready;

    // sequencer: per-sample judge, end-of-frame flush, last pending result
    always_comb
    begin
        state_next      = state_reg;
        row_pos_next    = row_pos_reg;
        col_pos_next    = col_pos_reg;
        hold_valid_next = hold_valid_reg;
        hold_row_next   = hold_row_reg;
        hold_col_next   = hold_col_reg;
        left_next       = left_reg;
        rows_cfg_next   = rows_cfg_reg;
        cols_cfg_next   = cols_cfg_reg;
        cell_ctl        = '0;
        ins_upper       = cell_upper[0];
        ins_middle      = cell_middle[0];
        push            = 1'b0;
        push_last       = 1'b1;
        push_row        = row_pos_reg - 1'b1;
        push_col        = col_pos_reg;
        peak_now        = (row_pos_reg != '0) && ge_all;

        case (state_reg)
            ST_RUN:
            begin
                if (sample_accept)
                begin
                    cell_ctl.shift = 1'b1;
                    ins_middle     = samples.sample;
                    if (row_pos_reg != '0)
                    begin
                        ins_upper = centre;
                    end
                    left_next = centre;
                    if (col_pos_reg != last_col)
                    begin
                        col_pos_next = col_pos_reg + 1'b1;
                        push         = peak_now;
                    end
                    else if (row_pos_reg != last_row)
                    begin
                        col_pos_next = '0;
                        row_pos_next = row_pos_reg + 1'b1;
                        push         = peak_now;
                    end
                    else
                    begin
                        // last word of the frame: result waits for the flush
                        hold_valid_next = peak_now;
                        hold_row_next   = row_pos_reg - 1'b1;
                        hold_col_next   = col_pos_reg;
                        col_pos_next    = '0;
                        state_next      = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (advance)
                begin
                    cell_ctl.shift = 1'b1;
                    left_next      = centre;
                    if (ge_all)
                    begin
                        if (hold_valid_reg)
                        begin
                            push      = 1'b1;
                            push_last = 1'b0;
                            push_row  = hold_row_reg;
                            push_col  = hold_col_reg;
                        end
                        hold_valid_next = 1'b1;
                        hold_row_next   = row_pos_reg;
                        hold_col_next   = col_pos_reg;
                    end
                    if (col_pos_reg == last_col)
                    begin
                        cell_ctl.clear = 1'b1;
                        row_pos_next   = '0;
                        col_pos_next   = '0;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        col_pos_next = col_pos_reg + 1'b1;
                    end
                end
            end
            ST_FIN:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_RUN;
                end
                else if (advance)
                begin
                    push            = 1'b1;
                    push_row        = hold_row_reg;
                    push_col        = hold_col_reg;
                    hold_valid_next = 1'b0;
                    state_next      = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        // register write restarts the frame
        if (cfg_we)
        begin
            cell_ctl.clear  = 1'b1;
            row_pos_next    = '0;
            col_pos_next    = '0;
            hold_valid_next = 1'b0;
            state_next      = ST_RUN;
            case (cfg_index)
                CFG_ROWS: rows_cfg_next = cfg_wdata;
                CFG_COLS: cols_cfg_next = cfg_wdata[COLS_CFG_W-1:0];
                default:  ;
            endcase
        end
    end

    // output stage
    always_comb
    begin
        out_valid_next = out_valid_reg && !peaks.ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_row_next   = push_row[ROW_PORT_W-1:0];
            out_col_next   = push_col[COL_PORT_W-1:0];
            out_last_next  = push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            hold_valid_reg <= 1'b0;
            hold_row_reg   <= '0;
            hold_col_reg   <= '0;
            left_reg       <= '0;
            rows_cfg_reg   <= ROWS_RESET;
            cols_cfg_reg   <= COLS_RESET;
            out_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_pos_reg    <= row_pos_next;
            col_pos_reg    <= col_pos_next;
            hold_valid_reg <= hold_valid_next;
            hold_row_reg   <= hold_row_next;
            hold_col_reg   <= hold_col_next;
            left_reg       <= left_next;
            rows_cfg_reg   <= rows_cfg_next;
            cols_cfg_reg   <= cols_cfg_next;
            out_valid_reg  <= out_valid_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign peaks.valid       = out_valid_reg;
    assign peaks.peak_row    = out_row_reg;
    assign peaks.peak_col    = out_col_reg;
    assign peaks.last_of_run = out_last_reg;

    // checks
    `GLP_ASSERT_IMP(a_hold_only_in_flush, hold_valid_reg, state_reg != ST_RUN, "pending result left in run state")
    `GLP_ASSERT(a_col_in_frame, col_pos_reg <= last_col, "column position beyond frame width")
    `GLP_ASSERT(a_row_in_frame, row_pos_reg <= last_row, "row position beyond frame height")

endmodule

// ===== tb/sv/grid_local_peak_finder_top_tb.sv =====
// Self-checking testbench for grid_local_peak_finder_top: random grids in raster order,
// random idles on both streams and a running model that predicts each peak word.
// Depends on glp_pkg, the glp_if stream interfaces and the peak finder RTL.
module grid_local_peak_finder_top_tb;
    import glp_pkg::*;

    localparam int SAMPLE_W     = 16;
    localparam int GRID_COLS    = 32;
    localparam int GRID_ROWS    = 128;
    localparam int RANDOM_ITEMS = 310;
    localparam int SETTLE_GAP   = 48;      // room for the flush of the last row
    localparam int CYCLE_LIMIT  = 3000000;

    typedef struct packed {
        logic [ROW_PORT_W-1:0] row;
        logic [COL_PORT_W-1:0] col;
        logic                  last_of_run;
    } peak_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // stream side variables, known from time zero
    logic src_valid = 1'b0;
    logic [SAMPLE_W-1:0] src_sample = '0;
    logic sink_ready = 1'b0;

    glp_sample_if #(.SAMPLE_WIDTH(SAMPLE_W)) sample_bus ();
    glp_peak_if peak_bus ();

    assign sample_bus.valid  = src_valid;
    assign sample_bus.sample = src_sample;
    assign peak_bus.ready    = sink_ready;

    grid_local_peak_finder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_bus),
        .peaks     (peak_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // grid model state
    logic [ROWS_CFG_W-1:0] rows_reg = ROWS_RESET;
    logic [COLS_CFG_W-1:0] cols_reg = COLS_RESET;
    logic signed [SAMPLE_W-1:0] upper_row [GRID_COLS];
    logic signed [SAMPLE_W-1:0] judged_row [GRID_COLS];
    int row_pos = 0;
    int col_pos = 0;

    logic [SAMPLE_W-1:0] pending_samples [$];
    peak_word_t expected_peaks [$];
    int items_queued = 0;
    int items_accepted = 0;
    int mismatches = 0;
    int cycle_count = 0;

    logic sample_taken = 1'b0;
    logic peak_taken = 1'b0;

    // driver and sink pacing
    int src_gap = 0;
    bit src_loaded = 1'b0;
    bit src_calm = 1'b0;
    logic [SAMPLE_W-1:0] src_next = '0;
    int sink_wait = 0;
    bit sink_calm = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("grid_local_peak_finder_top regression: fail");
            $finish;
        end
    end

    function automatic int eff_rows_of(input logic [ROWS_CFG_W-1:0] v);
        if (v == 0) return 1;
        if (int'(v) > GRID_ROWS) return GRID_ROWS;
        return int'(v);
    endfunction

    function automatic int eff_cols_of(input logic [COLS_CFG_W-1:0] v);
        if (v == 0) return 1;
        if (int'(v) > GRID_COLS) return GRID_COLS;
        return int'(v);
    endfunction

    // four-neighbour test, all compares signed
    function automatic bit is_peak(input logic signed [SAMPLE_W-1:0] center,
                                   input logic signed [SAMPLE_W-1:0] up,
                                   input logic signed [SAMPLE_W-1:0] down,
                                   input logic signed [SAMPLE_W-1:0] lft,
                                   input logic signed [SAMPLE_W-1:0] rgt);
        return center >= up && center >= down && center >= lft && center >= rgt;
    endfunction

    function automatic peak_word_t make_peak(input int r, input int c);
        peak_word_t w;
        w.row = ROW_PORT_W'(r);
        w.col = COL_PORT_W'(c);
        w.last_of_run = 1'b0;
        return w;
    endfunction

    task automatic restart_frame();
        for (int i = 0; i < GRID_COLS; i++) upper_row[i] = '0;
        row_pos = 0;
        col_pos = 0;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_ROWS) rows_reg = data[ROWS_CFG_W-1:0];
        else if (idx == CFG_COLS) cols_reg = data[COLS_CFG_W-1:0];
        restart_frame();
    endtask

    // Advance the grid model by one sample and queue the peak words it causes.
    task automatic take_sample(input logic signed [SAMPLE_W-1:0] s);
        int rows;
        int cols;
        int r;
        int c;
        logic signed [SAMPLE_W-1:0] center;
        logic signed [SAMPLE_W-1:0] up;
        logic signed [SAMPLE_W-1:0] lft;
        logic signed [SAMPLE_W-1:0] rgt;
        peak_word_t found [$];
        peak_word_t w;
        rows = eff_rows_of(rows_reg);
        cols = eff_cols_of(cols_reg);
        r = row_pos;
        c = col_pos;
        if (r >= rows || c >= cols) begin
            r = 0;
            c = 0;
        end
        // first row only fills the line; later rows judge the cell above
        if (r == 0) begin
            judged_row[c] = s;
        end else begin
            center = judged_row[c];
            up = upper_row[c];
            upper_row[c] = center;
            lft = (c > 0) ? upper_row[c-1] : '0;
            rgt = (c + 1 < cols) ? judged_row[c+1] : '0;
            judged_row[c] = s;
            if (is_peak(center, up, s, lft, rgt)) found.push_back(make_peak(r - 1, c));
        end
        if (c + 1 < cols) begin
            col_pos = c + 1;
            row_pos = r;
        end else if (r + 1 < rows) begin
            col_pos = 0;
            row_pos = r + 1;
        end else begin
            // end of frame: last row against a zero row below
            for (int i = 0; i < cols; i++) begin
                lft = (i > 0) ? judged_row[i-1] : '0;
                rgt = (i + 1 < cols) ? judged_row[i+1] : '0;
                if (is_peak(judged_row[i], upper_row[i], '0, lft, rgt))
                    found.push_back(make_peak(r, i));
            end
            restart_frame();
        end
        for (int i = 0; i < found.size(); i++) begin
            w = found[i];
            w.last_of_run = (i == found.size() - 1);
            expected_peaks.push_back(w);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0d] peak word mismatch: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic check_peak(input peak_word_t got);
        peak_word_t want;
        if (expected_peaks.size() == 0) begin
            report_mismatch($sformatf("unexpected word row %0d col %0d last %0b",
                                      got.row, got.col, got.last_of_run));
        end else begin
            want = expected_peaks.pop_front();
            if (got.row != want.row)
                report_mismatch($sformatf("peak_row %0d, want %0d", got.row, want.row));
            if (got.col != want.col)
                report_mismatch($sformatf("peak_col %0d, want %0d", got.col, want.col));
            if (got.last_of_run != want.last_of_run)
                report_mismatch($sformatf("last_of_run %0b, want %0b at row %0d col %0d",
                                          got.last_of_run, want.last_of_run,
                                          want.row, want.col));
        end
    endtask

    // Monitor: model update on accepted samples, check on accepted peak words.
    always @(posedge clk) begin
        peak_word_t got;
        if (!rst_n) begin
            sample_taken <= 1'b0;
            peak_taken <= 1'b0;
        end else begin
            if (sample_bus.valid && sample_bus.ready) begin
                take_sample(sample_bus.sample);
                items_accepted++;
            end
            if (peak_bus.valid && peak_bus.ready) begin
                got.row = peak_bus.peak_row;
                got.col = peak_bus.peak_col;
                got.last_of_run = peak_bus.last_of_run;
                check_peak(got);
            end
            sample_taken <= sample_bus.valid && sample_bus.ready;
            peak_taken <= peak_bus.valid && peak_bus.ready;
        end
    end

    // Driver: one sample word per handshake, random gap before each word.
    always @(negedge clk) begin
        if (!rst_n) begin
            src_valid <= 1'b0;
            src_gap = 0;
            src_loaded = 1'b0;
        end else if (!src_valid || sample_taken) begin
            if (!src_loaded && pending_samples.size() != 0) begin
                src_next = pending_samples.pop_front();
                if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
                src_gap = src_calm ? 0 : $urandom_range(0, 17);
                src_loaded = 1'b1;
            end
            if (src_loaded && src_gap == 0) begin
                src_valid <= 1'b1;
                src_sample <= src_next;
                src_loaded = 1'b0;
            end else begin
                src_valid <= 1'b0;
                if (src_loaded) src_gap--;
            end
        end
    end

    // Sink: random stall after each accepted peak word.
    always @(negedge clk) begin
        if (!rst_n) begin
            sink_ready <= 1'b0;
            sink_wait = 0;
        end else if (peak_taken || !sink_ready) begin
            if (peak_taken) begin
                if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
                sink_wait = sink_calm ? 0 : $urandom_range(0, 17);
            end
            if (sink_wait == 0) begin
                sink_ready <= 1'b1;
            end else begin
                sink_ready <= 1'b0;
                sink_wait--;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
        pending_samples.push_back(s);
        items_queued++;
    endtask

    // wait until the block has drained, then leave room for a silent flush
    task automatic settle();
        while (items_accepted != items_queued || expected_peaks.size() != 0) @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // 0: any value, 1: small values for ties, 2: extremes, 3: a mix
    function automatic logic [SAMPLE_W-1:0] draw_sample(input int style);
        int pick;
        int v;
        logic [31:0] raw;
        pick = (style == 3) ? $urandom_range(0, 2) : style;
        if (pick == 0) begin
            raw = $urandom;
            return raw[SAMPLE_W-1:0];
        end
        if (pick == 1) begin
            v = $urandom_range(0, 4);
            v = v - 2;
            return v[SAMPLE_W-1:0];
        end
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    initial begin
        int directed_count;
        int kind;
        int frame_size;
        int count;
        int style;
        logic [CFG_DATA_W-1:0] rows_v;
        logic [CFG_DATA_W-1:0] cols_v;

        restart_frame();
        for (int i = 0; i < GRID_COLS; i++) judged_row[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single cell frames at reset settings: most negative, most positive, zero
        queue_sample(16'h8000);
        queue_sample(16'h7fff);
        queue_sample(16'h0000);
        settle();

        // zero in both registers acts as one
        write_reg(CFG_ROWS, 8'd0);
        write_reg(CFG_COLS, 8'd0);
        queue_sample(16'h0005);
        queue_sample(16'hfffb);
        settle();

        // single-row flat frame: every cell is a peak
        write_reg(CFG_COLS, 8'd5);
        write_reg(CFG_ROWS, 8'd1);
        repeat (5) queue_sample(16'h0000);
        settle();

        // 3x3 frame with extremes and ties
        write_reg(CFG_ROWS, 8'd3);
        write_reg(CFG_COLS, 8'd3);
        queue_sample(16'h7fff);
        queue_sample(16'hffff);
        queue_sample(16'h0001);
        queue_sample(16'h8000);
        queue_sample(16'h0000);
        queue_sample(16'h0000);
        queue_sample(16'h0001);
        queue_sample(16'hffff);
        queue_sample(16'h7fff);
        settle();
        directed_count = items_queued;

        // random phases: mostly small grids, now and then the largest sizes
        while (items_queued < directed_count + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 15);
            if (kind == 0) begin
                case ($urandom_range(0, 2))
                    0: rows_v = 8'd128;
                    1: rows_v = 8'd129;
                    default: rows_v = 8'd255;
                endcase
                cols_v = 8'($urandom_range(0, 1));
            end else if (kind == 1) begin
                rows_v = 8'($urandom_range(0, 2));
                case ($urandom_range(0, 3))
                    0: cols_v = 8'd32;
                    1: cols_v = 8'd33;
                    2: cols_v = 8'd63;
                    default: cols_v = 8'd255;
                endcase
            end else begin
                rows_v = 8'($urandom_range(1, 6));
                cols_v = 8'($urandom_range(1, 8));
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_ROWS, rows_v);
                write_reg(CFG_COLS, cols_v);
            end else begin
                write_reg(CFG_COLS, cols_v);
                write_reg(CFG_ROWS, rows_v);
            end
            frame_size = eff_rows_of(rows_v[ROWS_CFG_W-1:0]) *
                         eff_cols_of(cols_v[COLS_CFG_W-1:0]);
            count = (frame_size > 40) ? frame_size : frame_size * $urandom_range(1, 3);
            // sometimes leave a frame unfinished; the next write drops it
            if (frame_size > 1 && $urandom_range(0, 3) == 0)
                count += $urandom_range(1, frame_size - 1);
            style = $urandom_range(0, 3);
            repeat (count) queue_sample(draw_sample(style));
            settle();
        end

        if (mismatches == 0) begin
            $display("grid_local_peak_finder_top regression: pass");
        end else begin
            $display("grid_local_peak_finder_top regression: fail");
        end
        $finish;
    end

endmodule
